// File: rtl/msh_pkg.sv
// Package with the types, constants and helper functions of the string hash generator.
`default_nettype none
package msh_pkg;

	localparam int unsigned NUM_HASHES = 11;

	localparam logic [3:0] HASH_COUNT_MIN   = 4'd1;
	localparam logic [3:0] HASH_COUNT_MAX   = 4'd11;
	localparam logic [3:0] HASH_COUNT_RESET = 4'd10;

	// Hash function indexes.
	localparam int unsigned IDX_RS   = 0;
	localparam int unsigned IDX_JS   = 1;
	localparam int unsigned IDX_PJW  = 2;
	localparam int unsigned IDX_ELF  = 3;
	localparam int unsigned IDX_BKDR = 4;
	localparam int unsigned IDX_SDBM = 5;
	localparam int unsigned IDX_DJB  = 6;
	localparam int unsigned IDX_DEK  = 7;
	localparam int unsigned IDX_BP   = 8;
	localparam int unsigned IDX_FNV  = 9;
	localparam int unsigned IDX_AP   = 10;

	localparam logic [31:0] RS_MUL_SEED = 32'd63689;
	localparam logic [31:0] RS_MUL_STEP = 32'd378551;
	localparam logic [31:0] JS_SEED     = 32'd1315423911;
	localparam logic [31:0] PJW_HIGH    = 32'hF000_0000;
	localparam logic [31:0] DJB_SEED    = 32'd5381;
	localparam logic [31:0] FNV_MUL     = 32'h811C_9DC5;
	localparam logic [31:0] AP_SEED     = 32'hAAAA_AAAA;

	typedef logic [3:0] hash_cnt_t;
	typedef logic [NUM_HASHES-1:0][31:0] hash_vec_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       last_byte;
	} in_t;

	typedef struct packed {
		logic [3:0]  hash_index;
		logic [31:0] hash_value;
		logic        last_result;
	} out_t;

	// One byte request handed from the input register to the accumulators.
	typedef struct packed {
		logic       valid;
		logic [7:0] byte_value;
		logic       last_byte;
	} step_t;

	// Load request from the input side to the result emitter.
	typedef struct packed {
		logic      load;
		hash_cnt_t count;
	} emit_ctl_t;

	function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
		logic [63:0] w;
		w = {v, v} << s;
		return w[63:32];
	endfunction

	// Shared step of the PJW and ELF hashes.
	function automatic logic [31:0] pjw_step(input logic [31:0] h, input logic [31:0] c);
		logic [31:0] t;
		logic [31:0] x;
		t = (h << 4) + c;
		x = t & PJW_HIGH;
		return (t ^ (x >> 24)) & ~PJW_HIGH;
	endfunction

endpackage
`default_nettype wire

// File: rtl/msh_core.sv
// Hash accumulators: absorb a byte per cycle on step.valid; give a key's finished hashes.
`default_nettype none
module msh_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire msh_pkg::step_t     step,
	output msh_pkg::hash_vec_t      final_hash
);

	msh_pkg::hash_vec_t acc_q;
	msh_pkg::hash_vec_t acc_next;
	logic [31:0]        rs_mul_q;
	logic [31:0]        rs_mul_next;
	logic [31:0]        count_q;
	logic [31:0]        count_next;
	logic [31:0]        c;
	logic [31:0]        ap_prod;
	logic [31:0]        rs_prod;
	logic [31:0]        fnv_prod;
	logic [4:0]         dek_shift;

	assign c = {{24{step.byte_value[7]}}, step.byte_value};

	assign rs_prod  = acc_q[msh_pkg::IDX_RS] * rs_mul_q;
	assign fnv_prod = acc_q[msh_pkg::IDX_FNV] * msh_pkg::FNV_MUL;
	assign ap_prod  = c * (acc_q[msh_pkg::IDX_AP] >> 3);

	always_comb begin
		acc_next = acc_q;
		acc_next[msh_pkg::IDX_RS] = rs_prod + c;
		acc_next[msh_pkg::IDX_JS] = acc_q[msh_pkg::IDX_JS] ^ ((acc_q[msh_pkg::IDX_JS] << 5) + c
			+ (acc_q[msh_pkg::IDX_JS] >> 2));
		acc_next[msh_pkg::IDX_PJW] = msh_pkg::pjw_step(acc_q[msh_pkg::IDX_PJW], c);
		acc_next[msh_pkg::IDX_ELF] = msh_pkg::pjw_step(acc_q[msh_pkg::IDX_ELF], c);
		acc_next[msh_pkg::IDX_BKDR] = (acc_q[msh_pkg::IDX_BKDR] << 7)
			+ (acc_q[msh_pkg::IDX_BKDR] << 1) + acc_q[msh_pkg::IDX_BKDR] + c;
		acc_next[msh_pkg::IDX_SDBM] = c + (acc_q[msh_pkg::IDX_SDBM] << 6)
			+ (acc_q[msh_pkg::IDX_SDBM] << 16) - acc_q[msh_pkg::IDX_SDBM];
		acc_next[msh_pkg::IDX_DJB] = (acc_q[msh_pkg::IDX_DJB] << 5) + acc_q[msh_pkg::IDX_DJB] + c;
		acc_next[msh_pkg::IDX_DEK] = msh_pkg::rotl32(acc_q[msh_pkg::IDX_DEK], 5'd5) ^ c;
		acc_next[msh_pkg::IDX_BP] = (acc_q[msh_pkg::IDX_BP] << 7) ^ c;
		acc_next[msh_pkg::IDX_FNV] = fnv_prod ^ c;
		// AP alternates between two update forms by byte position.
		if (!count_q[0]) begin
			acc_next[msh_pkg::IDX_AP] = acc_q[msh_pkg::IDX_AP]
				^ ((acc_q[msh_pkg::IDX_AP] << 7) ^ ap_prod);
		end else begin
			acc_next[msh_pkg::IDX_AP] = acc_q[msh_pkg::IDX_AP]
				^ ~(((acc_q[msh_pkg::IDX_AP] << 11) + c) ^ (acc_q[msh_pkg::IDX_AP] >> 5));
		end
	end

	assign rs_mul_next = rs_mul_q * msh_pkg::RS_MUL_STEP;
	assign count_next  = count_q + 32'd1;
	// Rotate amount is 5 * length modulo 32.
	assign dek_shift   = count_next[4:0] + {count_next[2:0], 2'b00};

	always_comb begin
		final_hash = acc_next;
		// Folding in the length this way equals seeding DEK with the key length.
		final_hash[msh_pkg::IDX_DEK] = acc_next[msh_pkg::IDX_DEK]
			^ msh_pkg::rotl32(count_next, dek_shift);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			acc_q[msh_pkg::IDX_JS]  <= msh_pkg::JS_SEED;
			acc_q[msh_pkg::IDX_DJB] <= msh_pkg::DJB_SEED;
			acc_q[msh_pkg::IDX_AP]  <= msh_pkg::AP_SEED;
			rs_mul_q <= msh_pkg::RS_MUL_SEED;
			count_q  <= '0;
		end else if (step.valid) begin
			if (step.last_byte) begin
				acc_q    <= '0;
				acc_q[msh_pkg::IDX_JS]  <= msh_pkg::JS_SEED;
				acc_q[msh_pkg::IDX_DJB] <= msh_pkg::DJB_SEED;
				acc_q[msh_pkg::IDX_AP]  <= msh_pkg::AP_SEED;
				rs_mul_q <= msh_pkg::RS_MUL_SEED;
				count_q  <= '0;
			end else begin
				acc_q    <= acc_next;
				rs_mul_q <= rs_mul_next;
				count_q  <= count_next;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/msh_emit.sv
// Result emitter: holds a key's finished hashes, sends one per cycle on out_ready.
`default_nettype none
module msh_emit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire msh_pkg::emit_ctl_t  ctl,
	input  wire msh_pkg::hash_vec_t  final_hash,
	output logic                     free,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output msh_pkg::out_t            out_data
);

	msh_pkg::hash_vec_t snap_q;
	logic [3:0]         idx_q;
	logic [3:0]         last_idx_q;
	logic               busy_q;
	logic               is_last;
	logic               take;

	assign is_last   = (idx_q == last_idx_q);
	assign take      = busy_q && out_ready;
	assign free      = !busy_q || (take && is_last);
	assign out_valid = busy_q;

	assign out_data.hash_index  = idx_q;
	assign out_data.hash_value  = snap_q[0];
	assign out_data.last_result = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			idx_q      <= '0;
			last_idx_q <= '0;
		end else if (ctl.load) begin
			busy_q     <= 1'b1;
			idx_q      <= '0;
			last_idx_q <= ctl.count - 4'd1;
		end else if (take) begin
			if (is_last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 4'd1;
			end
		end
	end

	// The hash on show always sits in entry zero; the rest move down as results leave.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			snap_q <= final_hash;
		end else if (take) begin
			for (int k = 0; k < msh_pkg::NUM_HASHES - 1; k++) begin
				snap_q[k] <= snap_q[k+1];
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/multi_string_hash_generator_unit.sv
// Top level of the multi-function string hash generator.
//
// A key enters one byte per request on the input channel (in_valid/in_ready,
// in_data), with last_byte set on its final byte. Eleven 32-bit string hashes
// (RS, JS, PJW, ELF, BKDR, SDBM, DJB, DEK, BP, FNV, AP) are updated for every byte.
// After the last byte the first hash_count hashes leave on the output channel
// (out_valid/out_ready, out_data) in index order, last_result marking the final one.
// hash_count is written through cfg_we/cfg_wdata; 0 is stored as 1 and values
// above 11 as 11. It resets to 10.
// A byte passes through the input register; after the last byte the hashes are
// loaded into the result register, which then shows the key's first result.
// Throughput: one byte per cycle. A key's results leave at one per cycle while
// the receiver is ready; the next key's bytes keep flowing meanwhile, and only
// its last byte waits in the input register until the result register has sent
// its final result. When the receiver stalls, the result on show is held, and
// input stops once a last byte is waiting. Reset reseeds all accumulators and
// empties both registers.
`default_nettype none
module multi_string_hash_generator_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire msh_pkg::in_t      in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output msh_pkg::out_t          out_data,
	input  wire logic              cfg_we,
	input  wire logic [3:0]        cfg_wdata
);

	logic               valid_s1;
	msh_pkg::in_t       data_s1;
	msh_pkg::hash_cnt_t hash_count_q;
	logic               emit_free;
	logic               advance;
	msh_pkg::step_t     step;
	msh_pkg::emit_ctl_t ctl;
	msh_pkg::hash_vec_t final_hash;

	assign advance  = valid_s1 && (!data_s1.last_byte || emit_free);
	assign in_ready = !valid_s1 || advance;

	assign step.valid      = advance;
	assign step.byte_value = data_s1.byte_value;
	assign step.last_byte  = data_s1.last_byte;

	assign ctl.load  = advance && data_s1.last_byte;
	assign ctl.count = hash_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_count_q <= msh_pkg::HASH_COUNT_RESET;
		end else if (cfg_we) begin
			if (cfg_wdata < msh_pkg::HASH_COUNT_MIN) begin
				hash_count_q <= msh_pkg::HASH_COUNT_MIN;
			end else if (cfg_wdata > msh_pkg::HASH_COUNT_MAX) begin
				hash_count_q <= msh_pkg::HASH_COUNT_MAX;
			end else begin
				hash_count_q <= cfg_wdata;
			end
		end
	end

	msh_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.final_hash (final_hash)
	);

	msh_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.final_hash (final_hash),
		.free       (emit_free),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

	// Results of a key leave with consecutive indexes.
	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last_result
		|=> out_valid && (out_data.hash_index == $past(out_data.hash_index) + 4'd1))
		else $error("hash index did not advance by one");

	// A burst of results starts at index zero.
	a_first_index: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> out_data.hash_index == 4'd0)
		else $error("first result of a key is not index zero");

	// Input only stalls behind a waiting last byte.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && data_s1.last_byte && out_valid)
		else $error("input stalled without a pending last byte");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		hash_count_q >= msh_pkg::HASH_COUNT_MIN && hash_count_q <= msh_pkg::HASH_COUNT_MAX)
		else $error("hash count out of range");

endmodule
`default_nettype wire
